// ===== rtl/core/midi_message_assembler_assert.svh =====
// Assertion macros shared by the MIDI message assembler checkers.
// Each macro expands to one labelled concurrent assertion with its own clock and reset.
`ifndef MIDI_MESSAGE_ASSEMBLER_ASSERT_SVH
`define MIDI_MESSAGE_ASSEMBLER_ASSERT_SVH

// Same-cycle implication.
`define MMA_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error("mma assertion failed");

// Next-cycle implication.
`define MMA_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error("mma assertion failed");

`endif

// ===== rtl/core/mma_pkg.sv =====
// Package for the MIDI message assembler: byte constants, the packet command type
// passed from the parser to the serialiser, and the data length decoder. No dependencies.
`timescale 1ns / 1ps

package mma_pkg;

	localparam logic [7:0] MIDI_SYSEX_START = 8'hF0;
	localparam logic [7:0] MIDI_SYSEX_END   = 8'hF7;
	localparam logic [7:0] MIDI_SONG_POS    = 8'hF2;
	localparam logic [7:0] MIDI_TIME_CODE   = 8'hF1;
	localparam logic [7:0] MIDI_SONG_SEL    = 8'hF3;
	localparam logic [3:0] MIDI_HI_PROG     = 4'hC;
	localparam logic [3:0] MIDI_HI_PRESSURE = 4'hD;
	localparam logic [3:0] MIDI_HI_SYSTEM   = 4'hF;
	localparam logic [4:0] MIDI_RT_PREFIX   = 5'b11111;

	localparam int QUEUE_DEPTH = 4;
	localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);

	// One packet command: up to three bytes; only the first may carry a packet start.
	typedef struct packed {
		logic [1:0] cnt;
		logic       start;
		logic [7:0] b0;
		logic [7:0] b1;
		logic [7:0] b2;
	} cmd_t;

	function automatic logic [1:0] data_count_of(input logic [7:0] s);
		logic [1:0] n;
		begin
			if (s[7:4] == MIDI_HI_PROG || s[7:4] == MIDI_HI_PRESSURE) begin
				n = 2'd1;
			end else if (s[7:4] != MIDI_HI_SYSTEM) begin
				n = 2'd2;
			end else if (s == MIDI_TIME_CODE || s == MIDI_SONG_SEL) begin
				n = 2'd1;
			end else if (s == MIDI_SONG_POS) begin
				n = 2'd2;
			end else begin
				n = 2'd0;
			end
			return n;
		end
	endfunction

endpackage

// ===== rtl/core/mma_front.sv =====
// Parser front end: takes one MIDI byte per transfer, tracks running status and SysEx
// chunking, and issues one packet command per byte that yields output. Uses mma_pkg.
`timescale 1ns / 1ps

module mma_front
	import mma_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       accept,
	input  logic [7:0] in_byte,
	input  logic       end_of_read,
	output logic       push,
	output cmd_t       cmd
);

	logic [7:0] running_status_q;
	logic [7:0] pending_status_q;
	logic [6:0] first_data_q;
	logic       have_q;
	logic [1:0] need_q;
	logic       in_sysex_q;
	logic       chunk_open_q;

	logic [7:0] n_rs;
	logic [7:0] n_ps;
	logic [6:0] n_fd;
	logic       n_have;
	logic [1:0] n_need;
	logic       n_sysex;
	logic       n_chunk;
	cmd_t       c;

	always_comb begin
		logic       done;
		logic [7:0] ps;
		logic [1:0] need;
		logic       have;
		logic       ok;
		logic [1:0] dc;
		n_rs    = running_status_q;
		n_ps    = pending_status_q;
		n_fd    = first_data_q;
		n_have  = have_q;
		n_need  = need_q;
		n_sysex = in_sysex_q;
		n_chunk = chunk_open_q;
		c       = '0;
		done    = 1'b0;
		ps      = pending_status_q;
		need    = need_q;
		have    = have_q;
		ok      = 1'b1;
		dc      = data_count_of(in_byte);
		if (in_byte[7:3] == MIDI_RT_PREFIX) begin
			n_chunk = 1'b0;
			c.cnt   = 2'd1;
			c.start = 1'b1;
			c.b0    = in_byte;
		end else if (in_byte[7]) begin
			if (in_sysex_q) begin
				n_sysex = 1'b0;
				n_chunk = 1'b0;
				if (in_byte == MIDI_SYSEX_END) begin
					c.cnt   = 2'd1;
					c.start = !chunk_open_q;
					c.b0    = in_byte;
					done    = 1'b1;
				end
			end
			if (!done) begin
				if (in_byte == MIDI_SYSEX_START) begin
					n_sysex = 1'b1;
					n_rs    = '0;
					n_ps    = '0;
					n_chunk = 1'b1;
					c.cnt   = 2'd1;
					c.start = 1'b1;
					c.b0    = in_byte;
				end else if (in_byte != MIDI_SYSEX_END) begin
					n_rs   = (in_byte[7:4] != MIDI_HI_SYSTEM) ? in_byte : 8'h00;
					n_ps   = in_byte;
					n_have = 1'b0;
					n_need = dc;
					if (dc == 2'd0) begin
						c.cnt   = 2'd1;
						c.start = 1'b1;
						c.b0    = in_byte;
						n_ps    = '0;
					end
				end
			end
		end else if (in_sysex_q) begin
			c.cnt   = 2'd1;
			c.start = !chunk_open_q;
			c.b0    = in_byte;
			n_chunk = 1'b1;
		end else begin
			// no open message: fall back on running status, or drop
			if (pending_status_q == 8'h00) begin
				if (running_status_q == 8'h00) begin
					ok = 1'b0;
				end else begin
					ps   = running_status_q;
					have = 1'b0;
					need = data_count_of(running_status_q);
				end
			end
			if (ok) begin
				n_ps   = ps;
				n_need = need;
				if (!have && need[1]) begin
					n_fd   = in_byte[6:0];
					n_have = 1'b1;
				end else begin
					c.cnt   = need[1] ? 2'd3 : 2'd2;
					c.start = 1'b1;
					c.b0    = ps;
					c.b1    = need[1] ? {1'b0, first_data_q} : in_byte;
					c.b2    = in_byte;
					n_ps    = '0;
					n_have  = 1'b0;
				end
			end
		end
		if (end_of_read) begin
			n_chunk = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			running_status_q <= '0;
			pending_status_q <= '0;
			first_data_q     <= '0;
			have_q           <= 1'b0;
			need_q           <= '0;
			in_sysex_q       <= 1'b0;
			chunk_open_q     <= 1'b0;
		end else if (accept) begin
			running_status_q <= n_rs;
			pending_status_q <= n_ps;
			first_data_q     <= n_fd;
			have_q           <= n_have;
			need_q           <= n_need;
			in_sysex_q       <= n_sysex;
			chunk_open_q     <= n_chunk;
		end
	end

	assign push = accept && (c.cnt != 2'd0);
	assign cmd  = c;

endmodule

// ===== rtl/core/mma_cmd_fifo.sv =====
// Short command queue between the parser and the serialiser, held in flip-flops,
// with a fall-through head. Uses mma_pkg for the command type and depth.
`timescale 1ns / 1ps

module mma_cmd_fifo
	import mma_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  cmd_t push_cmd,
	input  logic pop,
	output logic full,
	output logic nonempty,
	output cmd_t head
);

	cmd_t                mem_q [QUEUE_DEPTH];
	logic [QUEUE_AW-1:0] wr_ptr_q;
	logic [QUEUE_AW-1:0] rd_ptr_q;
	logic [QUEUE_AW:0]   count_q;

	logic do_push;
	logic do_pop;

	assign full     = (count_q == QUEUE_AW'(0) + (QUEUE_AW+1)'(QUEUE_DEPTH));
	assign nonempty = (count_q != '0);
	assign do_push  = push && !full;
	assign do_pop   = pop && nonempty;
	assign head     = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= push_cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			case ({do_push, do_pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

// ===== rtl/core/mma_back.sv =====
// Serialiser back end: takes packet commands from the queue and drives one result
// byte per transfer on the output stream. Uses mma_pkg for the command type.
`timescale 1ns / 1ps

module mma_back
	import mma_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       q_nonempty,
	input  cmd_t       q_head,
	output logic       q_pop,
	output logic       m_tvalid,
	input  logic       m_tready,
	output logic [7:0] m_tdata,
	output logic [0:0] m_tuser,
	output logic       m_tlast
);

	cmd_t       cur_q;
	logic [1:0] idx_q;
	logic       busy_q;

	logic is_last;

	assign is_last = (idx_q == cur_q.cnt - 2'd1);
	// load the next command when idle or as the last byte of this one transfers
	assign q_pop   = q_nonempty && (!busy_q || (m_tready && is_last));

	always_comb begin
		case (idx_q)
			2'd0:    m_tdata = cur_q.b0;
			2'd1:    m_tdata = cur_q.b1;
			default: m_tdata = cur_q.b2;
		endcase
	end

	assign m_tvalid   = busy_q;
	assign m_tuser[0] = cur_q.start && (idx_q == 2'd0);
	assign m_tlast    = is_last;

	always_ff @(posedge clk) begin
		if (q_pop) begin
			cur_q <= q_head;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			idx_q  <= '0;
		end else if (q_pop) begin
			busy_q <= 1'b1;
			idx_q  <= '0;
		end else if (busy_q && m_tready) begin
			if (is_last) begin
				busy_q <= 1'b0;
				idx_q  <= '0;
			end else begin
				idx_q <= idx_q + 2'd1;
			end
		end
	end

endmodule

// ===== rtl/core/midi_message_assembler.sv =====
// MIDI message assembler top level.
// Input stream s_*: one raw MIDI byte per transfer in s_tdata[7:0]; s_tlast marks the
// last byte of one read and closes any open SysEx chunk.
// Output stream m_*: packet bytes, one per transfer. m_tuser[0] flags the first byte of
// a packet, m_tlast the final result caused by one input byte.
// Channel messages come out whole once their data bytes are in, running status expanded;
// real-time bytes pass at once; SysEx streams through in chunks.
// With the queue empty, the first result of a byte is offered once its command has
// been written to the queue and then loaded into the serialiser. Input rate is one byte
// per cycle while the queue is not full; the serialiser gives one result per cycle while
// m_tready is high, so a byte yielding three results takes three output transfers.
// A four-entry command queue sits between parser and serialiser; s_tready drops only
// while it is full, so a stalled receiver backs up into the input after five commands
// (one in the serialiser, four queued).
// Reset clears running status, any open message and SysEx state, and empties the queue.
// Depends on mma_pkg, mma_front, mma_cmd_fifo and mma_back.
`timescale 1ns / 1ps

module midi_message_assembler
	import mma_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       s_tvalid,
	output logic       s_tready,
	input  logic [7:0] s_tdata,    // [7:0] in_byte
	input  logic       s_tlast,
	output logic       m_tvalid,
	input  logic       m_tready,
	output logic [7:0] m_tdata,    // [7:0] out_byte
	output logic [0:0] m_tuser,    // [0] packet_start
	output logic       m_tlast
);

	logic accept;
	logic push;
	cmd_t push_cmd;
	logic q_full;
	logic q_nonempty;
	logic q_pop;
	cmd_t q_head;

	assign s_tready = !q_full;
	assign accept   = s_tvalid && s_tready;

	mma_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.accept      (accept),
		.in_byte     (s_tdata),
		.end_of_read (s_tlast),
		.push        (push),
		.cmd         (push_cmd)
	);

	mma_cmd_fifo u_fifo (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_cmd (push_cmd),
		.pop      (q_pop),
		.full     (q_full),
		.nonempty (q_nonempty),
		.head     (q_head)
	);

	mma_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.q_nonempty (q_nonempty),
		.q_head     (q_head),
		.q_pop      (q_pop),
		.m_tvalid   (m_tvalid),
		.m_tready   (m_tready),
		.m_tdata    (m_tdata),
		.m_tuser    (m_tuser),
		.m_tlast    (m_tlast)
	);

endmodule

// ===== rtl/core/mma_sva_checker.sv =====
// Port-level checker for the MIDI message assembler, bound to the top level.
// Depends on midi_message_assembler_assert.svh for the assertion macros and mma_pkg.
`timescale 1ns / 1ps
`include "midi_message_assembler_assert.svh"

module mma_sva_checker
	import mma_pkg::*;
(
	input logic       clk,
	input logic       arst_n,
	input logic       m_tvalid,
	input logic       m_tready,
	input logic [7:0] m_tdata,
	input logic [0:0] m_tuser,
	input logic       m_tlast
);

	logic       out_stall;
	logic [9:0] out_word;
	logic       out_rt;
	logic       out_mid_status;
	logic       out_chan_status;

	assign out_stall       = m_tvalid && !m_tready;
	assign out_word        = {m_tdata, m_tuser, m_tlast};
	assign out_rt          = m_tvalid && (m_tdata[7:3] == MIDI_RT_PREFIX);
	assign out_mid_status  = m_tvalid && !m_tuser[0] && m_tdata[7];
	assign out_chan_status = m_tvalid && m_tdata[7] && (m_tdata[7:4] != MIDI_HI_SYSTEM);

	// a stalled result holds
	`MMA_ASSERT_NEXT(a_out_hold, clk, arst_n, out_stall, m_tvalid && $stable(out_word))

	// real-time bytes always form a packet of their own
	`MMA_ASSERT_NOW(a_rt_alone, clk, arst_n, out_rt, m_tuser[0] && m_tlast)

	// a status byte that continues a packet can only be end of SysEx
	`MMA_ASSERT_NOW(a_mid_status, clk, arst_n, out_mid_status, m_tdata == MIDI_SYSEX_END)

	// a channel status is always followed by its data
	`MMA_ASSERT_NOW(a_chan_not_last, clk, arst_n, out_chan_status, !m_tlast)

endmodule

bind midi_message_assembler mma_sva_checker u_mma_sva_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tuser  (m_tuser),
	.m_tlast  (m_tlast)
);

// ===== verif/tb.sv =====
// Self-checking bench for midi_message_assembler: random and directed MIDI byte streams,
// predicted packet bytes compared transfer by transfer. Depends on mma_pkg and the RTL.
`timescale 1ns / 1ps

module tb
	import mma_pkg::*;
();

	localparam int ITEM_TARGET = 274;
	localparam int CYCLE_LIMIT = 200000;
	localparam int QUIET_TAIL  = 40;

	localparam logic [7:0] ST_NOTE_ON  = 8'h90;
	localparam logic [7:0] ST_PITCH    = 8'hE0;
	localparam logic [7:0] ST_UNDEF_F4 = 8'hF4;
	localparam logic [7:0] ST_UNDEF_F5 = 8'hF5;
	localparam logic [7:0] ST_TUNE_REQ = 8'hF6;
	localparam logic [7:0] CHAN_FIRST  = 8'h80;
	localparam logic [7:0] CHAN_LAST   = 8'hEF;
	localparam logic [7:0] RT_CLOCK    = 8'hF8;
	localparam logic [7:0] RT_RESET    = 8'hFF;

	typedef struct packed {
		logic [7:0] data;
		logic       eor;
	} midi_in_t;

	typedef struct packed {
		logic [7:0] data;
		logic       first;
		logic       last;
	} midi_out_t;

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       s_tvalid = 1'b0;
	logic       s_tready;
	logic [7:0] s_tdata = 8'h00;    // [7:0] in_byte
	logic       s_tlast = 1'b0;
	logic       m_tvalid;
	logic       m_tready = 1'b0;
	logic [7:0] m_tdata;            // [7:0] out_byte
	logic [0:0] m_tuser;            // [0] packet_start
	logic       m_tlast;

	midi_in_t  pending_bytes[$];
	midi_out_t packet_bytes_q[$];

	// assembler state as the bench sees it
	logic [7:0] run_status;
	logic [7:0] open_status;
	logic [6:0] held_data;
	int         got_n;
	int         want_n;
	logic       sysex_on;
	logic       chunk_live;

	int   bytes_taken = 0;
	int   bad_count = 0;
	int   cyc = 0;
	int   src_gap = 0;
	int   snk_gap = 0;
	logic calm = 1'b0;
	midi_in_t  nxt;
	midi_out_t want;

	midi_message_assembler dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tlast  (s_tlast),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic int msg_len(input logic [7:0] s);
		if (s[7:4] == MIDI_HI_PROG || s[7:4] == MIDI_HI_PRESSURE) return 1;
		if (s[7:4] != MIDI_HI_SYSTEM) return 2;
		case (s)
			MIDI_TIME_CODE, MIDI_SONG_SEL: return 1;
			MIDI_SONG_POS:                 return 2;
			default:                       return 0;
		endcase
	endfunction

	// Work out the packet bytes one received byte gives and queue them.
	task automatic assemble_byte(input logic [7:0] b, input logic eor);
		midi_out_t res[3];
		int        n;
		logic      closed;
		n = 0;
		closed = 1'b0;
		if (b[7:3] == MIDI_RT_PREFIX) begin
			chunk_live = 1'b0;
			res[n] = '{b, 1'b1, 1'b0};
			n++;
		end else if (b[7]) begin
			if (sysex_on) begin
				sysex_on = 1'b0;
				if (b == MIDI_SYSEX_END) begin
					res[n] = '{b, !chunk_live, 1'b0};
					n++;
					closed = 1'b1;
				end
				chunk_live = 1'b0;
			end
			if (!closed) begin
				if (b == MIDI_SYSEX_START) begin
					sysex_on = 1'b1;
					run_status = 8'h00;
					open_status = 8'h00;
					res[n] = '{b, 1'b1, 1'b0};
					n++;
					chunk_live = 1'b1;
				end else if (b != MIDI_SYSEX_END) begin
					run_status = (b[7:4] != MIDI_HI_SYSTEM) ? b : 8'h00;
					open_status = b;
					got_n = 0;
					want_n = msg_len(b);
					if (want_n == 0) begin
						res[n] = '{b, 1'b1, 1'b0};
						n++;
						open_status = 8'h00;
					end
				end
			end
		end else if (sysex_on) begin
			res[n] = '{b, !chunk_live, 1'b0};
			n++;
			chunk_live = 1'b1;
		end else if (open_status != 8'h00 || run_status != 8'h00) begin
			if (open_status == 8'h00) begin
				open_status = run_status;
				got_n = 0;
				want_n = msg_len(run_status);
			end
			if (got_n == 0 && want_n == 2) begin
				held_data = b[6:0];
				got_n = 1;
			end else begin
				res[n] = '{open_status, 1'b1, 1'b0};
				n++;
				if (want_n == 2) begin
					res[n] = '{{1'b0, held_data}, 1'b0, 1'b0};
					n++;
				end
				res[n] = '{b, 1'b0, 1'b0};
				n++;
				open_status = 8'h00;
				got_n = 0;
			end
		end
		if (eor) chunk_live = 1'b0;
		for (int i = 0; i < n; i++) begin
			res[i].last = (i == n - 1);
			packet_bytes_q.push_back(res[i]);
		end
	endtask

	task automatic queue_byte(input logic [7:0] b, input logic eor);
		pending_bytes.push_back('{b, eor});
	endtask

	function automatic logic rnd_eor();
		return $urandom_range(0, 7) == 0;
	endfunction

	function automatic logic [7:0] rnd_rt();
		return 8'($urandom_range(RT_CLOCK, RT_RESET));
	endfunction

	// source side: predict on each transfer, then offer the next byte or idle
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_tvalid <= 1'b0;
			s_tdata <= 8'h00;
			s_tlast <= 1'b0;
			run_status = 8'h00;
			open_status = 8'h00;
			held_data = 7'h00;
			got_n = 0;
			want_n = 0;
			sysex_on = 1'b0;
			chunk_live = 1'b0;
		end else begin
			if (s_tvalid && s_tready) begin
				assemble_byte(s_tdata, s_tlast);
				bytes_taken++;
			end
			if (!s_tvalid || s_tready) begin
				if (src_gap > 0 && !calm) begin
					src_gap--;
					s_tvalid <= 1'b0;
				end else if (pending_bytes.size() > 0) begin
					nxt = pending_bytes.pop_front();
					s_tvalid <= 1'b1;
					s_tdata <= nxt.data;
					s_tlast <= nxt.eor;
					if (!calm && cyc[9:8] != 2'b01 && $urandom_range(0, 5) == 0) begin
						src_gap = $urandom_range(1, 16);
					end
				end else begin
					s_tvalid <= 1'b0;
				end
			end
		end
	end

	// sink side: check each transfer against the oldest predicted byte
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tready <= 1'b0;
			snk_gap = 0;
		end else begin
			if (m_tvalid && m_tready) begin
				if (packet_bytes_q.size() == 0) begin
					if (bad_count < 10) begin
						$display("unexpected output: byte %h start %b last %b",
							m_tdata, m_tuser[0], m_tlast);
					end
					bad_count++;
				end else begin
					want = packet_bytes_q.pop_front();
					if (m_tdata !== want.data || m_tuser[0] !== want.first ||
						m_tlast !== want.last) begin
						if (bad_count < 10) begin
							$display("mismatch: expected %h/%b/%b, got %h/%b/%b",
								want.data, want.first, want.last,
								m_tdata, m_tuser[0], m_tlast);
						end
						bad_count++;
					end
				end
			end
			if (snk_gap > 0 && !calm) begin
				snk_gap--;
				m_tready <= 1'b0;
			end else begin
				m_tready <= 1'b1;
				if (!calm && cyc[8:7] != 2'b00 && $urandom_range(0, 7) == 0) begin
					snk_gap = $urandom_range(1, 16);
				end
			end
		end
	end

	always @(posedge clk) begin
		cyc++;
		if (cyc == CYCLE_LIMIT) begin
			$display("Verification failed");
			$finish;
		end
	end

	initial begin
		logic [7:0] status;
		logic [7:0] last_chan;
		int         pick;
		int         len;
		int         total;

		// directed: orphan data, stray end of SysEx, running status, real-time inside a
		// message, system common, zero-length status and each way a SysEx chunk ends
		queue_byte(8'h00, 1'b0);
		queue_byte(8'h7F, 1'b0);
		queue_byte(MIDI_SYSEX_END, 1'b0);
		queue_byte(ST_NOTE_ON, 1'b0);
		queue_byte(8'h3C, 1'b0);
		queue_byte(RT_CLOCK, 1'b0);
		queue_byte(8'h7F, 1'b1);
		queue_byte(8'h00, 1'b0);
		queue_byte(8'h7F, 1'b0);
		queue_byte({MIDI_HI_PROG, 4'h5}, 1'b0);
		queue_byte(8'h01, 1'b0);
		queue_byte(MIDI_SONG_POS, 1'b0);
		queue_byte(8'h11, 1'b0);
		queue_byte(8'h22, 1'b0);
		queue_byte(8'h40, 1'b0);
		queue_byte(ST_UNDEF_F4, 1'b0);
		queue_byte(MIDI_SYSEX_START, 1'b0);
		queue_byte(8'h01, 1'b1);
		queue_byte(RT_RESET, 1'b0);
		queue_byte(8'h02, 1'b0);
		queue_byte(MIDI_SYSEX_END, 1'b0);
		queue_byte(MIDI_SYSEX_START, 1'b1);
		queue_byte(MIDI_SYSEX_END, 1'b0);
		queue_byte(MIDI_SYSEX_START, 1'b0);
		queue_byte(ST_PITCH, 1'b0);
		queue_byte(8'h12, 1'b0);
		queue_byte(8'h34, 1'b0);
		queue_byte(MIDI_TIME_CODE, 1'b0);
		queue_byte(8'h55, 1'b0);

		last_chan = 8'h00;
		while (pending_bytes.size() < ITEM_TARGET) begin
			pick = $urandom_range(0, 99);
			if (pick < 45) begin
				// channel message, often by running status
				if (last_chan == 8'h00 || $urandom_range(0, 2) != 0) begin
					status = 8'($urandom_range(CHAN_FIRST, CHAN_LAST));
					queue_byte(status, rnd_eor());
					last_chan = status;
				end
				len = msg_len(last_chan);
				for (int j = 0; j < len; j++) begin
					if ($urandom_range(0, 9) == 0) queue_byte(rnd_rt(), rnd_eor());
					queue_byte(8'($urandom_range(0, 127)), rnd_eor());
				end
			end else if (pick < 60) begin
				case ($urandom_range(0, 5))
					0:       status = MIDI_TIME_CODE;
					1:       status = MIDI_SONG_POS;
					2:       status = MIDI_SONG_SEL;
					3:       status = ST_UNDEF_F4;
					4:       status = ST_UNDEF_F5;
					default: status = ST_TUNE_REQ;
				endcase
				queue_byte(status, rnd_eor());
				len = msg_len(status);
				for (int j = 0; j < len; j++) begin
					queue_byte(8'($urandom_range(0, 127)), rnd_eor());
				end
				last_chan = 8'h00;
			end else if (pick < 75) begin
				queue_byte(MIDI_SYSEX_START, rnd_eor());
				len = $urandom_range(0, 8);
				for (int j = 0; j < len; j++) begin
					if ($urandom_range(0, 7) == 0) queue_byte(rnd_rt(), rnd_eor());
					queue_byte(8'($urandom_range(0, 127)), rnd_eor());
				end
				// leave some open so the next status ends them
				if ($urandom_range(0, 3) != 0) queue_byte(MIDI_SYSEX_END, rnd_eor());
				last_chan = 8'h00;
			end else if (pick < 85) begin
				queue_byte(rnd_rt(), rnd_eor());
			end else begin
				queue_byte(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
			end
		end
		total = pending_bytes.size();

		repeat (12) @(posedge clk);
		arst_n <= 1'b1;

		while (pending_bytes.size() >= QUIET_TAIL) @(posedge clk);
		calm <= 1'b1;
		while (bytes_taken < total) @(posedge clk);
		while (packet_bytes_q.size() != 0) @(posedge clk);
		repeat (10) @(posedge clk);

		if (bad_count == 0 && packet_bytes_q.size() == 0) begin
			$display("Verification passed");
		end else begin
			$display("Verification failed");
		end
		$finish;
	end

endmodule
